// File: src/raster_sync_span_tracker_assert.svh
// Assertion macros for the raster sync span tracker.
`ifndef RASTER_SYNC_SPAN_TRACKER_ASSERT_SVH
`define RASTER_SYNC_SPAN_TRACKER_ASSERT_SVH

// Check a combinational implication at every clock edge outside reset.
`define RSST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition in this cycle implies a condition in the next one.
`define RSST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rsst_pkg.sv
// Shared constants and types for the raster sync span tracker.
package rsst_pkg;

    localparam int TIME_BITS_DEFAULT = 48;
    localparam int ROW_BITS_DEFAULT  = 10;
    localparam int LEVEL_BITS        = 8;
    localparam int FRAME_BITS        = 32;
    localparam int ACTION_BITS       = 2;

    localparam logic [ACTION_BITS-1:0] ACT_VIDEO  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_HBLANK = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_VBLANK = 2'd2;

    typedef struct packed {
        logic span_valid;
        logic frame_done;
        logic geometry_changed;
    } rsst_flags_t;

endpackage

// File: src/raster_sync_span_tracker.sv
// Top level of the raster sync span tracker: input, state and result registers.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    action, video_value, event_time
//  out       output     out_valid / out_stall  span_*, frame_*, geometry_changed,
//                                              line_length, field_lines
//  cfg       input      cfg_we                 cfg_wdata (interlaced)
//
// One item per cycle sustained while out_stall is low; an accepted item passes through the
// input register, then the step logic into the result register.
// The state register feeds back through the step logic.
// Reset clears all pin levels, timers, counters and the interlaced bit.
// A stalled result holds; one more item is taken into the input register.
module raster_sync_span_tracker #(
    parameter int TIME_BITS = rsst_pkg::TIME_BITS_DEFAULT,
    parameter int ROW_BITS  = rsst_pkg::ROW_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rsst_pkg::ACTION_BITS-1:0]    action,
    input  logic [rsst_pkg::LEVEL_BITS-1:0]     video_value,
    input  logic [TIME_BITS-1:0]                event_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                span_valid,
    output logic [TIME_BITS-1:0]                span_start,
    output logic [TIME_BITS-1:0]                span_end,
    output logic [ROW_BITS-1:0]                 span_row,
    output logic [rsst_pkg::LEVEL_BITS-1:0]     span_color,
    output logic                                frame_done,
    output logic [rsst_pkg::FRAME_BITS-1:0]     frame_number,
    output logic                                geometry_changed,
    output logic [TIME_BITS-1:0]                line_length,
    output logic [ROW_BITS-1:0]                 field_lines
);
    import rsst_pkg::*;

    `include "raster_sync_span_tracker_assert.svh"

    logic                    interlaced_reg;
    logic                    in_valid_reg;
    logic [ACTION_BITS-1:0]  action_reg;
    logic [LEVEL_BITS-1:0]   value_reg;
    logic [TIME_BITS-1:0]    time_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    advance;
    logic                    in_load;

    logic [LEVEL_BITS-1:0]   video_level_reg,  video_level_next;
    logic                    hblank_reg,       hblank_next;
    logic                    vblank_reg,       vblank_next;
    logic [ROW_BITS-1:0]     row_reg,          row_next;
    logic [ROW_BITS-1:0]     field_reg,        field_next;
    logic [TIME_BITS-1:0]    measured_reg,     measured_next;
    logic [TIME_BITS-1:0]    line_start_reg,   line_start_next;
    logic [TIME_BITS-1:0]    prev_time_reg,    prev_time_next;
    logic [FRAME_BITS-1:0]   frames_reg,       frames_next;

    rsst_flags_t             flags;
    rsst_flags_t             flags_reg;
    logic [TIME_BITS-1:0]    span_start_w, span_start_reg;
    logic [TIME_BITS-1:0]    span_end_w,   span_end_reg;
    logic [ROW_BITS-1:0]     span_row_w,   span_row_reg;
    logic [LEVEL_BITS-1:0]   span_color_w, span_color_reg;

    // Process the held item whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_load  = in_valid && !in_stall;

    always_comb
    begin
        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    rsst_step #(
        .TIME_BITS (TIME_BITS),
        .ROW_BITS  (ROW_BITS)
    ) u_step (
        .interlaced               (interlaced_reg),
        .action                   (action_reg),
        .video_value              (value_reg),
        .event_time               (time_reg),
        .video_level              (video_level_reg),
        .hblank_level             (hblank_reg),
        .vblank_level             (vblank_reg),
        .row_position             (row_reg),
        .field_height             (field_reg),
        .measured_line_time       (measured_reg),
        .line_start_time          (line_start_reg),
        .previous_event_time      (prev_time_reg),
        .frames_seen              (frames_reg),
        .video_level_next         (video_level_next),
        .hblank_level_next        (hblank_next),
        .vblank_level_next        (vblank_next),
        .row_position_next        (row_next),
        .field_height_next        (field_next),
        .measured_line_time_next  (measured_next),
        .line_start_time_next     (line_start_next),
        .previous_event_time_next (prev_time_next),
        .frames_seen_next         (frames_next),
        .flags                    (flags),
        .span_start               (span_start_w),
        .span_end                 (span_end_w),
        .span_row                 (span_row_w),
        .span_color               (span_color_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interlaced_reg  <= 1'b0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            video_level_reg <= '0;
            hblank_reg      <= 1'b0;
            vblank_reg      <= 1'b0;
            row_reg         <= '0;
            field_reg       <= '0;
            measured_reg    <= '0;
            line_start_reg  <= '0;
            prev_time_reg   <= '0;
            frames_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                interlaced_reg <= cfg_wdata;
            end
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                video_level_reg <= video_level_next;
                hblank_reg      <= hblank_next;
                vblank_reg      <= vblank_next;
                row_reg         <= row_next;
                field_reg       <= field_next;
                measured_reg    <= measured_next;
                line_start_reg  <= line_start_next;
                prev_time_reg   <= prev_time_next;
                frames_reg      <= frames_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            action_reg <= action;
            value_reg  <= video_value;
            time_reg   <= event_time;
        end
        if (advance)
        begin
            flags_reg      <= flags;
            span_start_reg <= span_start_w;
            span_end_reg   <= span_end_w;
            span_row_reg   <= span_row_w;
            span_color_reg <= span_color_w;
        end
    end

    assign out_valid        = out_valid_reg;
    assign span_valid       = flags_reg.span_valid;
    assign span_start       = span_start_reg;
    assign span_end         = span_end_reg;
    assign span_row         = span_row_reg;
    assign span_color       = span_color_reg;
    assign frame_done       = flags_reg.frame_done;
    assign geometry_changed = flags_reg.geometry_changed;
    // State was updated along with the result, so these track it exactly.
    assign frame_number     = frames_reg;
    assign line_length      = measured_reg;
    assign field_lines      = field_reg;

    `RSST_ASSERT_NOW(a_frame_no_span, out_valid && frame_done, !span_valid,
        "span painted on a frame end result")
    `RSST_ASSERT_NOW(a_blank_span_zero, out_valid && !span_valid,
        span_row == '0 && span_color == '0 && span_end == '0,
        "span fields not cleared on unpainted result")
    `RSST_ASSERT_NOW(a_no_overrun, in_load, !in_valid_reg || advance,
        "input register overwritten while holding an item")
    `RSST_ASSERT_NEXT(a_state_holds, !advance, $stable(frames_reg) && $stable(row_reg),
        "tracker state changed without an item")

endmodule

// File: src/rsst_step.sv
// Event decode and state update for one pin-change item.
module rsst_step #(
    parameter int TIME_BITS = rsst_pkg::TIME_BITS_DEFAULT,
    parameter int ROW_BITS  = rsst_pkg::ROW_BITS_DEFAULT
) (
    input  logic                                interlaced,
    input  logic [rsst_pkg::ACTION_BITS-1:0]    action,
    input  logic [rsst_pkg::LEVEL_BITS-1:0]     video_value,
    input  logic [TIME_BITS-1:0]                event_time,
    input  logic [rsst_pkg::LEVEL_BITS-1:0]     video_level,
    input  logic                                hblank_level,
    input  logic                                vblank_level,
    input  logic [ROW_BITS-1:0]                 row_position,
    input  logic [ROW_BITS-1:0]                 field_height,
    input  logic [TIME_BITS-1:0]                measured_line_time,
    input  logic [TIME_BITS-1:0]                line_start_time,
    input  logic [TIME_BITS-1:0]                previous_event_time,
    input  logic [rsst_pkg::FRAME_BITS-1:0]     frames_seen,
    output logic [rsst_pkg::LEVEL_BITS-1:0]     video_level_next,
    output logic                                hblank_level_next,
    output logic                                vblank_level_next,
    output logic [ROW_BITS-1:0]                 row_position_next,
    output logic [ROW_BITS-1:0]                 field_height_next,
    output logic [TIME_BITS-1:0]                measured_line_time_next,
    output logic [TIME_BITS-1:0]                line_start_time_next,
    output logic [TIME_BITS-1:0]                previous_event_time_next,
    output logic [rsst_pkg::FRAME_BITS-1:0]     frames_seen_next,
    output rsst_pkg::rsst_flags_t               flags,
    output logic [TIME_BITS-1:0]                span_start,
    output logic [TIME_BITS-1:0]                span_end,
    output logic [ROW_BITS-1:0]                 span_row,
    output logic [rsst_pkg::LEVEL_BITS-1:0]     span_color
);
    import rsst_pkg::*;

    logic [TIME_BITS-1:0] since_line;
    logic [TIME_BITS-1:0] since_prev;
    logic [ROW_BITS-1:0]  row_odd;
    logic                 paint;

    assign since_line = event_time - line_start_time;
    assign since_prev = previous_event_time - line_start_time;
    assign row_odd    = row_position | ROW_BITS'(1);

    always_comb
    begin
        row_position_next       = row_position;
        field_height_next       = field_height;
        measured_line_time_next = measured_line_time;
        line_start_time_next    = line_start_time;
        frames_seen_next        = frames_seen;
        paint                   = 1'b0;
        flags                   = '0;

        priority if (action == ACT_VBLANK && !vblank_level)
        begin
            // Frame end: latch the field height from the final row.
            if ((interlaced ? row_odd : row_position) != field_height)
            begin
                flags.geometry_changed = 1'b1;
            end
            row_position_next = interlaced ? row_odd : row_position;
            field_height_next = interlaced ? row_odd : row_position;
            frames_seen_next  = frames_seen + FRAME_BITS'(1);
            flags.frame_done  = 1'b1;
        end
        else if (action == ACT_HBLANK && !hblank_level)
        begin
            // Re-measure the line only on rows inside the visible field.
            if (row_position != '0 && row_position < field_height &&
                since_line != measured_line_time)
            begin
                measured_line_time_next = since_line;
                flags.geometry_changed  = 1'b1;
            end
            paint             = 1'b1;
            row_position_next = row_position + ROW_BITS'(interlaced ? 2 : 1);
        end
        else if (action == ACT_VBLANK)
        begin
            // A long half-line before vblank ends marks the odd field.
            row_position_next = (interlaced && since_line > measured_line_time) ?
                                ROW_BITS'(1) : '0;
        end
        else if (action == ACT_HBLANK)
        begin
            line_start_time_next = event_time;
        end
        else
        begin
            paint = !hblank_level && !vblank_level;
        end

        flags.span_valid = paint && (video_level != '0 || interlaced);
    end

    assign span_start = flags.span_valid ? since_prev   : '0;
    assign span_end   = flags.span_valid ? since_line   : '0;
    assign span_row   = flags.span_valid ? row_position : '0;
    assign span_color = flags.span_valid ? video_level  : '0;

    // Apply the pin change itself; the unused code leaves every level alone.
    assign video_level_next         = (action == ACT_VIDEO) ? video_value : video_level;
    assign hblank_level_next        = hblank_level ^ (action == ACT_HBLANK);
    assign vblank_level_next        = vblank_level ^ (action == ACT_VBLANK);
    assign previous_event_time_next = event_time;

endmodule
